// ----- hw/rtl/ut2fat_pkg.sv -----
// ----------------------------------------------------------------------------
// ut2fat_pkg
// Shared constants for the Unix time to FAT date/time converter.
// ----------------------------------------------------------------------------
package ut2fat_pkg;

  // Seconds per day is 128 * 675. The low 7 bits pass straight through and
  // the rest is divided by 675 with a reciprocal.
  localparam int unsigned DayShift    = 7;
  localparam logic [9:0]  DAY_LOW     = 10'd675;
  localparam int unsigned DayRecipSh  = 35;
  localparam logic [25:0] DAY_RECIP   = 26'd50903316;   // floor(2^35 / 675)

  // Days from 1970-01-01 to 1980-01-01
  localparam logic [15:0] DAYS_TO_1980 = 16'd3652;

  // Four-year groups
  localparam logic [15:0] DAYS_PER_GROUP = 16'd1461;
  localparam int unsigned GrpRecipSh     = 26;
  localparam logic [15:0] GRP_RECIP      = 16'd45933;   // floor(2^26 / 1461)

  // Division by 60
  localparam logic [5:0]  SIXTY         = 6'd60;
  localparam int unsigned MinRecipSh    = 22;
  localparam logic [16:0] MIN_RECIP     = 17'd69905;    // floor(2^22 / 60)
  localparam int unsigned HourRecipSh   = 16;
  localparam logic [10:0] HOUR_RECIP    = 11'd1092;     // floor(2^16 / 60)

  localparam logic [8:0]  LEAP_YEAR_LEN = 9'd366;
  localparam logic [8:0]  YEAR_LEN      = 9'd365;
  localparam logic [8:0]  FEB_END       = 9'd59;

  // First day of each month in a leap year, counted from 0
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0,   9'd31,  9'd60,  9'd91,  9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

endpackage

// ----- hw/rtl/unix_time_to_fat_datetime_unit.sv -----
// ----------------------------------------------------------------------------
// unix_time_to_fat_datetime_unit
// Converts a 32-bit Unix timestamp into packed FAT time and date words.
//
// Usage:
//   Input channel: in_valid_i / in_stall_o carry unix_seconds_i. An item is
//   taken at a rising edge with in_valid_i high and in_stall_o low.
//   Output channel: out_valid_o / out_stall_i carry fat_time_o, fat_date_o
//   and before_epoch_o. Timestamps before 1980-01-01 give before_epoch_o = 1
//   with both words zero.
//   Pipeline: six register stages between unix_seconds_i and the outputs.
//   Throughput: one item per cycle while the output does not stall. Each stage holds one item and
//   every constant division is a reciprocal multiply followed by a one-step
//   correction in the next stage, so no loop limits the rate.
//   Stall: a stalled result holds on the outputs. Earlier stages keep moving
//   into empty slots, so bubbles close up; in_stall_o rises only once every
//   stage is full behind a stalled result.
//   Reset: all stages are emptied; no result is pending after reset.
// ----------------------------------------------------------------------------
module unix_time_to_fat_datetime_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] unix_seconds_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] fat_time_o,
  output logic [15:0] fat_date_o,
  output logic        before_epoch_o
);
  import ut2fat_pkg::*;

  localparam int unsigned NumStages = 6;   // A..E plus output stage

  // ---------------------------------------------------------------- flow
  logic [NumStages-1:0] valid_q, valid_d, adv;

  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || !out_stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = adv[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = valid_q[NumStages-1];

  // ---------------------------------------------------------------- stage A
  // Estimate of days = (t >> 7) / 675, low by at most one.
  logic [50:0] a_prod;
  logic [31:0] sa_t_q;
  logic [15:0] sa_q0_q;

  assign a_prod = 51'(unix_seconds_i[31:DayShift]) * 51'(DAY_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      sa_t_q  <= unix_seconds_i;
      sa_q0_q <= a_prod[DayRecipSh+15:DayRecipSh];
    end
  end

  // ---------------------------------------------------------------- stage B
  // Correct the day count, rebuild second of day, split off the 1980 offset.
  logic [25:0] b_prod;
  logic [24:0] b_rem_full;
  logic [10:0] b_rem;
  logic        b_corr;
  logic [10:0] b_rem_fix;
  logic [15:0] b_days;
  logic [16:0] sb_sod_q;
  logic [15:0] sb_d_q;
  logic        sb_before_q;

  always_comb begin
    b_prod     = 26'(sa_q0_q) * 26'(DAY_LOW);
    b_rem_full = sa_t_q[31:DayShift] - b_prod[24:0];
    b_rem      = b_rem_full[10:0];
    b_corr     = b_rem >= 11'(DAY_LOW);
    b_rem_fix  = b_corr ? (b_rem - 11'(DAY_LOW)) : b_rem;
    b_days     = sa_q0_q + 16'(b_corr);
  end

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      sb_sod_q    <= {b_rem_fix[9:0], sa_t_q[DayShift-1:0]};
      sb_d_q      <= b_days - DAYS_TO_1980;
      sb_before_q <= b_days < DAYS_TO_1980;
    end
  end

  // ---------------------------------------------------------------- stage C
  // Estimates of minute of day and four-year group.
  logic [33:0] c_mprod;
  logic [31:0] c_gprod;
  logic [16:0] sc_sod_q;
  logic [15:0] sc_d_q;
  logic [10:0] sc_m0_q;
  logic [4:0]  sc_g0_q;
  logic        sc_before_q;

  assign c_mprod = 34'(sb_sod_q) * 34'(MIN_RECIP);
  assign c_gprod = 32'(sb_d_q) * 32'(GRP_RECIP);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      sc_sod_q    <= sb_sod_q;
      sc_d_q      <= sb_d_q;
      sc_m0_q     <= c_mprod[MinRecipSh+10:MinRecipSh];
      sc_g0_q     <= c_gprod[GrpRecipSh+4:GrpRecipSh];
      sc_before_q <= sb_before_q;
    end
  end

  // ---------------------------------------------------------------- stage D
  // Correct minute of day and group; remainders give second and day in group.
  logic [16:0] d_mprod, d_srem_full;
  logic [6:0]  d_srem;
  logic        d_scorr;
  logic [15:0] d_gprod, d_drem_full;
  logic [11:0] d_drem;
  logic        d_dcorr;
  logic [10:0] sd_m_q;
  logic [5:0]  sd_sec_q;
  logic [4:0]  sd_grp_q;
  logic [10:0] sd_doy_q;
  logic        sd_before_q;

  always_comb begin
    d_mprod     = 17'(sc_m0_q) * 17'(SIXTY);
    d_srem_full = sc_sod_q - d_mprod;
    d_srem      = d_srem_full[6:0];
    d_scorr     = d_srem >= 7'(SIXTY);
    d_gprod     = 16'(sc_g0_q) * DAYS_PER_GROUP;
    d_drem_full = sc_d_q - d_gprod;
    d_drem      = d_drem_full[11:0];
    d_dcorr     = d_drem >= 12'(DAYS_PER_GROUP);
  end

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      sd_m_q      <= sc_m0_q + 11'(d_scorr);
      sd_sec_q    <= d_scorr ? 6'(d_srem - 7'(SIXTY)) : d_srem[5:0];
      sd_grp_q    <= sc_g0_q + 5'(d_dcorr);
      sd_doy_q    <= d_dcorr ? 11'(d_drem - 12'(DAYS_PER_GROUP)) : d_drem[10:0];
      sd_before_q <= sc_before_q;
    end
  end

  // ---------------------------------------------------------------- stage E
  // Hour estimate; year within group, day of year mapped onto leap calendar.
  logic [21:0] e_hprod;
  logic [10:0] e_rest;
  logic [8:0]  e_doy;
  logic [1:0]  e_yy;
  logic [6:0]  e_year;
  logic [10:0] se_m_q;
  logic [5:0]  se_sec_q;
  logic [5:0]  se_h0_q;
  logic [6:0]  se_year_q;
  logic [8:0]  se_doy_q;
  logic        se_before_q;

  assign e_hprod = 22'(sd_m_q) * 22'(HOUR_RECIP);

  always_comb begin
    e_rest = sd_doy_q - 11'(LEAP_YEAR_LEN);
    e_yy   = 2'd0;
    e_doy  = sd_doy_q[8:0];
    if (sd_doy_q >= 11'(LEAP_YEAR_LEN)) begin
      if (e_rest >= 11'(2 * YEAR_LEN)) begin
        e_yy  = 2'd2;
        e_doy = 9'(e_rest - 11'(2 * YEAR_LEN));
      end else if (e_rest >= 11'(YEAR_LEN)) begin
        e_yy  = 2'd1;
        e_doy = 9'(e_rest - 11'(YEAR_LEN));
      end else begin
        e_doy = e_rest[8:0];
      end
      e_year = {sd_grp_q, 2'b00} + 7'd1 + 7'(e_yy);
    end else begin
      e_year = {sd_grp_q, 2'b00};
    end
    // common year: skip the leap day
    if (e_year[1:0] != 2'b00 && e_doy >= FEB_END) begin
      e_doy = e_doy + 9'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      se_m_q      <= sd_m_q;
      se_sec_q    <= sd_sec_q;
      se_h0_q     <= e_hprod[HourRecipSh+5:HourRecipSh];
      se_year_q   <= e_year;
      se_doy_q    <= e_doy;
      se_before_q <= sd_before_q;
    end
  end

  // ---------------------------------------------------------------- stage F
  // Hour correction, month lookup, packing.
  logic [10:0] f_hprod, f_mrem_full;
  logic [6:0]  f_mrem;
  logic        f_mcorr;
  logic [5:0]  f_min;
  logic [4:0]  f_hour;
  logic [3:0]  f_mo;
  logic [8:0]  f_day_full;
  logic [15:0] out_time_q, out_date_q;
  logic        out_before_q;

  always_comb begin
    f_hprod     = 11'(se_h0_q) * 11'(SIXTY);
    f_mrem_full = se_m_q - f_hprod;
    f_mrem      = f_mrem_full[6:0];
    f_mcorr     = f_mrem >= 7'(SIXTY);
    f_min       = f_mcorr ? 6'(f_mrem - 7'(SIXTY)) : f_mrem[5:0];
    f_hour      = 5'(se_h0_q) + 5'(f_mcorr);
    f_mo        = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (se_doy_q >= MONTH_START[k]) begin
        f_mo = 4'(k);
      end
    end
    f_day_full  = se_doy_q - MONTH_START[f_mo];
  end

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      out_before_q <= se_before_q;
      if (se_before_q) begin
        out_time_q <= '0;
        out_date_q <= '0;
      end else begin
        out_time_q <= {f_hour, f_min, se_sec_q[5:1]};
        out_date_q <= {se_year_q, f_mo + 4'd1, f_day_full[4:0] + 5'd1};
      end
    end
  end

  assign fat_time_o     = out_time_q;
  assign fat_date_o     = out_date_q;
  assign before_epoch_o = out_before_q;

  // ---------------------------------------------------------------- checks
  // Input only stalls when every stage is full behind a stalled result.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q) && out_stall_i)
    else $error("input stalled with a free stage");

  // Rebuilt second of day stays below one day.
  a_sod_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[1] |-> sb_sod_q < 17'd86400)
    else $error("second of day out of range");

  // Corrected group remainder lies within a group for valid timestamps.
  a_doy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[3] && !sd_before_q |-> sd_doy_q < 11'(DAYS_PER_GROUP))
    else $error("day in group out of range");

  // A valid result carries a month of 1 to 12, a nonzero day and a legal time of day.
  a_out_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !before_epoch_o |->
      fat_date_o[8:5] != 4'd0 && fat_date_o[8:5] <= 4'd12 &&
      fat_date_o[4:0] != 5'd0 && fat_time_o[15:11] <= 5'd23 &&
      fat_time_o[10:5] <= 6'd59 && fat_time_o[4:0] <= 5'd29)
    else $error("illegal date or time in result");

  // Pre-1980 results carry zero words.
  a_before_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && before_epoch_o |-> fat_time_o == 16'd0 && fat_date_o == 16'd0)
    else $error("pre-1980 result not zero");

endmodule

// ----- bench/ut2fat_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ut2fat_checker
// Watches both channels of the Unix time to FAT converter, works out the FAT
// words for every accepted timestamp and compares them in order with the
// results that leave the block.
// ----------------------------------------------------------------------------
module ut2fat_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] unix_seconds_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] fat_time_i,
  input  logic [15:0] fat_date_i,
  input  logic        before_epoch_i,
  output int          mismatches_o,
  output int          backlog_o
);

  localparam int unsigned SecsPerDay   = 86400;
  localparam int unsigned DaysTo1980   = 3652;
  localparam int unsigned DaysPerGroup = 1461;
  localparam int unsigned FebEnd       = 59;
  localparam int unsigned MonthDays [12] = '{31, 29, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [31:0] secs;
    logic [15:0] time_word;
    logic [15:0] date_word;
    logic        early;
  } fat_stamp_t;

  fat_stamp_t fat_words_q [$];
  fat_stamp_t oldest;

  function automatic fat_stamp_t to_fat(input logic [31:0] secs);
    int unsigned days, sod, grp, yr, doy, mo;
    fat_stamp_t  r;
    r = '0;
    r.secs = secs;
    days = secs / SecsPerDay;
    sod  = secs - days * SecsPerDay;
    if (days < DaysTo1980) begin
      r.early = 1'b1;
      return r;
    end
    r.time_word = 16'(((sod / 3600) << 11) | (((sod / 60) % 60) << 5) | ((sod % 60) >> 1));
    days = days - DaysTo1980;
    grp  = days / DaysPerGroup;
    doy  = days - grp * DaysPerGroup;
    yr   = grp * 4;
    // first year of a group is the leap year; the rest are common years
    if (doy >= 366) begin
      doy = doy - 366;
      yr  = yr + 1 + doy / 365;
      doy = doy % 365;
    end
    // common years skip Feb 29 of the leap table
    if ((yr % 4) != 0 && doy >= FebEnd) doy = doy + 1;
    mo = 0;
    while (mo < 11 && doy >= MonthDays[mo]) begin
      doy = doy - MonthDays[mo];
      mo  = mo + 1;
    end
    r.date_word = 16'((yr << 9) | ((mo + 1) << 5) | (doy + 1));
    return r;
  endfunction

  task automatic report(input string field, input logic [31:0] secs,
                        input logic [15:0] exp_val, input logic [15:0] act_val);
    $display("%0t: %s mismatch for %0d s: expected %h, actual %h",
             $time, field, secs, exp_val, act_val);
    mismatches_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fat_words_q.delete();
      mismatches_o = 0;
      backlog_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (fat_words_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual time %h date %h early %b",
                   $time, fat_time_i, fat_date_i, before_epoch_i);
          mismatches_o++;
        end else begin
          oldest = fat_words_q.pop_front();
          if (fat_time_i !== oldest.time_word)
            report("fat_time", oldest.secs, oldest.time_word, fat_time_i);
          if (fat_date_i !== oldest.date_word)
            report("fat_date", oldest.secs, oldest.date_word, fat_date_i);
          if (before_epoch_i !== oldest.early)
            report("before_epoch", oldest.secs, 16'(oldest.early), 16'(before_epoch_i));
        end
      end
      if (in_valid_i && !in_stall_i) fat_words_q.push_back(to_fat(unix_seconds_i));
      backlog_o = fat_words_q.size();
    end
  end

endmodule

// ----- bench/tb_unix_time_to_fat_datetime_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_unix_time_to_fat_datetime_unit
// Drives timestamps into the Unix time to FAT converter with random gaps and
// output stalls; a checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_unix_time_to_fat_datetime_unit;

  localparam int unsigned RandomItems = 600;
  localparam int unsigned CycleLimit  = 200000;
  // pipeline is six stages deep; leave room for a stray late result
  localparam int unsigned TailCycles  = 12;
  localparam logic [31:0] Epoch1980   = 32'd315532800;
  localparam int unsigned FirstDay    = 3652;     // 1980-01-01 as a day number
  localparam int unsigned LastFullDay = 49709;    // last whole day below 2^32 s
  localparam int unsigned Day2100     = 47482;    // 2100-01-01

  // Day offsets inside a four-year group that sit on month and year seams
  localparam int unsigned SeamDays [14] = '{
    0, 58, 59, 60, 364, 365, 366, 424, 425, 730, 731, 1095, 1096, 1460
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] unix_seconds_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [15:0] fat_time_o;
  logic [15:0] fat_date_o;
  logic        before_epoch_o;

  int          mismatches;
  int          backlog;
  int unsigned cycles = 0;

  unix_time_to_fat_datetime_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .unix_seconds_i (unix_seconds_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fat_time_o     (fat_time_o),
    .fat_date_o     (fat_date_o),
    .before_epoch_o (before_epoch_o)
  );

  ut2fat_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .unix_seconds_i (unix_seconds_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fat_time_i     (fat_time_o),
    .fat_date_i     (fat_date_o),
    .before_epoch_i (before_epoch_o),
    .mismatches_o   (mismatches),
    .backlog_o      (backlog)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Timestamp for a day number and a second of that day.
  function automatic logic [31:0] stamp(input int unsigned day, input int unsigned sod);
    return 32'(64'(day) * 64'd86400 + 64'(sod));
  endfunction

  // Idle cycles before an item: mostly none, some short, a few long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Random timestamp. Weighted toward the 1980 boundary, the day seams and
  // the leap-year corners, since those steer the date math.
  function automatic logic [31:0] pick_stamp();
    int unsigned r, day, sod;
    r = $urandom_range(0, 99);
    if (r < 15) return $urandom();
    if (r < 25) return $urandom_range(0, Epoch1980 - 1);
    if (r < 55) begin
      day = FirstDay + 1461 * $urandom_range(0, 31) + SeamDays[$urandom_range(0, 13)];
      if (day > LastFullDay) day = LastFullDay;
      case ($urandom_range(0, 3))
        0:       sod = 0;
        1:       sod = 86399;
        2:       sod = $urandom_range(0, 1);
        default: sod = $urandom_range(0, 86399);
      endcase
      return stamp(day, sod);
    end
    return $urandom_range(Epoch1980, 32'hFFFF_FFFF);
  endfunction

  // Present one item and hold it until the block takes it. Valid stays high
  // across back-to-back items; during a gap the data bus wanders freely.
  task automatic send_stamp(input logic [31:0] secs, input int unsigned gap);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i     <= 1'b0;
      unix_seconds_i <= $urandom();
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    unix_seconds_i <= secs;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Output back-pressure: short random stalls, long holds now and then, and
  // stretches with no stall at all.
  initial begin
    int unsigned hold_left;
    int unsigned r;
    logic        stall_now;
    out_stall_i = 1'b0;
    hold_left   = 0;
    stall_now   = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          stall_now = 1'b0;
          hold_left = $urandom_range(0, 3);
        end else if (r < 90) begin
          stall_now = 1'b1;
          hold_left = $urandom_range(0, 2);
        end else if (r < 96) begin
          stall_now = 1'b0;
          hold_left = $urandom_range(20, 60);
        end else begin
          stall_now = 1'b1;
          hold_left = $urandom_range(10, 30);
        end
      end
      out_stall_i <= stall_now;
    end
  end

  initial begin
    logic [31:0] corners [$];
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    unix_seconds_i = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed corners: field extremes, the 1980 boundary, the last day of a
    // leap year, Feb/Mar in leap and common years, and 2100 counted as leap.
    corners = '{
      32'd0, 32'd1, Epoch1980 - 1, Epoch1980, Epoch1980 + 1,
      32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA,
      stamp(FirstDay + 365, 0),             // 1980-12-31 00:00:00
      stamp(FirstDay + 365, 86399),         // 1980-12-31 23:59:59
      stamp(FirstDay + 366, 0),             // 1981-01-01
      stamp(FirstDay + 366 + 58, 86399),    // 1981-02-28 late
      stamp(FirstDay + 366 + 59, 0),        // 1981-03-01
      stamp(FirstDay + 1461 + 59, 43201),   // 1984-02-29 noon, odd second
      stamp(FirstDay + 1460, 86399),        // 1983-12-31 23:59:59
      stamp(Day2100 + 59, 0),               // Feb 29 of 2100
      stamp(Day2100 + 365, 3599),           // Dec 31 of 2100
      stamp(FirstDay + 7 * 1461 + 59, 45296)
    };
    foreach (corners[i]) send_stamp(corners[i], pick_gap());

    for (int unsigned n = 0; n < RandomItems; n++) send_stamp(pick_stamp(), pick_gap());

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // Drain, then give the pipeline time to show any extra result.
    while (backlog != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/ut2fat_pkg.sv
hw/rtl/unix_time_to_fat_datetime_unit.sv
bench/ut2fat_checker.sv
bench/tb_unix_time_to_fat_datetime_unit.sv
